[rtl/core/rvfp_pkg.sv]
`timescale 1ns / 1ps

package rvfp_pkg;

	// Input item actions.
	localparam logic [2:0] ACT_PORT_WRITE = 3'd0;
	localparam logic [2:0] ACT_LINE_REQ   = 3'd1;
	localparam logic [2:0] ACT_COLUMN_REQ = 3'd2;
	localparam logic [2:0] ACT_PIXEL_BYTE = 3'd3;
	localparam logic [2:0] ACT_TICK       = 3'd4;

	// I/O port numbers.
	localparam logic [7:0] PORT_BASE   = 8'hF5;
	localparam logic [7:0] PORT_ORIGIN = 8'hF6;
	localparam logic [7:0] PORT_MODE   = 8'hF7;

	// Mode register bits.
	localparam int MODE_ENABLE_BIT = 6;
	localparam int MODE_INVERT_BIT = 7;

	// Configuration register indexes.
	localparam logic CFG_REFRESH_PERIOD = 1'b0;
	localparam logic CFG_DISPLAY_ENABLE = 1'b1;

	localparam logic [15:0] REFRESH_PERIOD_RST = 16'd75;

	localparam int ADDR_W = 18;

	typedef struct packed {
		logic [2:0]  action;
		logic [7:0]  port_number;
		logic [7:0]  port_value;
		logic [7:0]  line_number;
		logic [15:0] roller_word;
		logic [6:0]  column_number;
		logic [7:0]  pixel_byte;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] fetch_address;
		logic [7:0]        pixel_bits;
		logic              blank;
		logic              redraw;
	} rsp_t;

endpackage

[rtl/core/roller_video_fetch_and_pixel_unit.sv]
`timescale 1ns / 1ps
// An accepted item waits in the input register, then passes into the result register.
// Throughput: one item per cycle; the input register and the result register
// hand over in the same cycle, so only a stalled result holds the input side.
// Reset (arst_n low, asynchronous): both stages empty, table base, scroll origin,
// mode and tick count cleared, refresh period 75, display enabled.

module roller_video_fetch_and_pixel_unit #(
	parameter int COLUMNS = 90,
	parameter int LINES   = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  rvfp_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output rvfp_pkg::rsp_t  rsp,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic [15:0]     cfg_data
);

	localparam logic [8:0] LINE_LIMIT = 9'(LINES);
	localparam logic [7:0] COL_LIMIT  = 8'(COLUMNS);

	logic            valid_s1;
	rvfp_pkg::req_t  req_s1;
	logic            rsp_valid_q;
	rvfp_pkg::rsp_t  rsp_q;

	logic [15:0] refresh_period_q;
	logic        display_enable_q;
	logic [7:0]  table_base_q;
	logic [7:0]  scroll_origin_q;
	logic [7:0]  mode_q;
	logic [15:0] tick_count_q;

	logic            advance;
	logic [7:0]      table_base_d;
	logic [7:0]      scroll_origin_d;
	logic [7:0]      mode_d;
	logic [15:0]     tick_count_d;
	logic [15:0]     tick_inc;
	logic [7:0]      line_slot;
	rvfp_pkg::rsp_t  rsp_d;

	// The input stage moves on whenever the result register is free or being taken.
	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign tick_inc  = tick_count_q + 16'd1;
	assign line_slot = req_s1.line_number + scroll_origin_q;

	// Result and next state for the item in the input stage.
	always_comb begin
		table_base_d    = table_base_q;
		scroll_origin_d = scroll_origin_q;
		mode_d          = mode_q;
		tick_count_d    = tick_count_q;
		rsp_d           = '0;
		unique case (req_s1.action)
			rvfp_pkg::ACT_PORT_WRITE: begin
				if (req_s1.port_number == rvfp_pkg::PORT_BASE) begin
					table_base_d = req_s1.port_value;
				end else if (req_s1.port_number == rvfp_pkg::PORT_ORIGIN) begin
					scroll_origin_d = req_s1.port_value;
				end else if (req_s1.port_number == rvfp_pkg::PORT_MODE) begin
					mode_d = req_s1.port_value;
				end
			end
			rvfp_pkg::ACT_LINE_REQ: begin
				if ({1'b0, req_s1.line_number} < LINE_LIMIT) begin
					rsp_d.fetch_address = {1'b0, table_base_q, line_slot, 1'b0};
				end
			end
			rvfp_pkg::ACT_COLUMN_REQ: begin
				if ({1'b0, req_s1.column_number} < COL_LIMIT) begin
					rsp_d.fetch_address = {1'b0, req_s1.roller_word[15:3], 1'b0,
						req_s1.roller_word[2:0]}
						+ {8'd0, req_s1.column_number, 3'd0};
				end
			end
			rvfp_pkg::ACT_PIXEL_BYTE: begin
				rsp_d.pixel_bits = mode_q[rvfp_pkg::MODE_INVERT_BIT] ?
					~req_s1.pixel_byte : req_s1.pixel_byte;
			end
			rvfp_pkg::ACT_TICK: begin
				if (tick_inc >= refresh_period_q) begin
					rsp_d.redraw = 1'b1;
					tick_count_d = '0;
				end else begin
					tick_count_d = tick_inc;
				end
			end
			default: begin
			end
		endcase
		// Blank reflects the mode as it stands after this item.
		rsp_d.blank = !display_enable_q || !mode_d[rvfp_pkg::MODE_ENABLE_BIT];
	end

	// Input stage and result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (!req_stall) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
		if (advance) begin
			rsp_q <= rsp_d;
		end
	end

	// Unit state, updated as each item completes its transfer into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_base_q    <= '0;
			scroll_origin_q <= '0;
			mode_q          <= '0;
			tick_count_q    <= '0;
		end else if (advance) begin
			table_base_q    <= table_base_d;
			scroll_origin_q <= scroll_origin_d;
			mode_q          <= mode_d;
			tick_count_q    <= tick_count_d;
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refresh_period_q <= rvfp_pkg::REFRESH_PERIOD_RST;
			display_enable_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rvfp_pkg::CFG_REFRESH_PERIOD: refresh_period_q <= cfg_data;
				rvfp_pkg::CFG_DISPLAY_ENABLE: display_enable_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

endmodule

[rtl/core/rvfp_checker.sv]
`timescale 1ns / 1ps

module rvfp_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic            req_stall,
	input  rvfp_pkg::req_t  req,
	input  logic            rsp_valid,
	input  logic            rsp_stall,
	input  rvfp_pkg::rsp_t  rsp,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic [15:0]     cfg_data
);

	// A stalled result is held until its transfer.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

	// With no result waiting, the input side never stalls.
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> !req_stall)
		else $error("input stalled while result register empty");

	// Every accepted item is followed by a result on show.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |-> ##2 rsp_valid)
		else $error("accepted item produced no result");

	// Of fetch_address, pixel_bits and redraw, at most one is ever nonzero.
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.redraw && (rsp.fetch_address != '0 || rsp.pixel_bits != '0))
			&& !(rsp.fetch_address != '0 && rsp.pixel_bits != '0))
		else $error("result mixes fields of different actions");

endmodule

bind roller_video_fetch_and_pixel_unit rvfp_checker u_rvfp_checker (.*);

[tb/sv/rvfp_fetch_checker.sv]
`timescale 1ns / 1ps

module rvfp_fetch_checker #(
	parameter int COLUMNS = 90,
	parameter int LINES   = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_stall,
	input  rvfp_pkg::req_t req,
	input  logic           rsp_valid,
	input  logic           rsp_stall,
	input  rvfp_pkg::rsp_t rsp,
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [15:0]    cfg_data,
	output int             fail_count,
	output int             pending
);

	// Shadow copy of the unit's registers and state.
	logic [15:0] refresh_period;
	logic        display_enable;
	logic [7:0]  table_base;
	logic [7:0]  scroll_origin;
	logic [7:0]  mode_bits;
	logic [15:0] tick_count;

	rvfp_pkg::rsp_t pending_video_results[$];
	rvfp_pkg::rsp_t oldest_result;
	int             mismatches = 0;

	assign fail_count = mismatches;

	// Print one line for the mismatch and count it.
	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("%0t mismatch: %s", $realtime, msg);
	endtask

	// Work out the result of one item and advance the shadow state.
	function automatic rvfp_pkg::rsp_t predict_video_result(input rvfp_pkg::req_t it);
		rvfp_pkg::rsp_t r;
		logic [7:0]     row;
		r = '0;
		case (it.action)
			rvfp_pkg::ACT_PORT_WRITE: begin
				if (it.port_number == rvfp_pkg::PORT_BASE) begin
					table_base = it.port_value;
				end else if (it.port_number == rvfp_pkg::PORT_ORIGIN) begin
					scroll_origin = it.port_value;
				end else if (it.port_number == rvfp_pkg::PORT_MODE) begin
					mode_bits = it.port_value;
				end
			end
			rvfp_pkg::ACT_LINE_REQ: begin
				// The table entry wraps within the 256 lines of the table.
				if (it.line_number < LINES) begin
					row = it.line_number + scroll_origin;
					r.fetch_address = {table_base, 9'd0} + {row, 1'b0};
				end
			end
			rvfp_pkg::ACT_COLUMN_REQ: begin
				if (it.column_number < COLUMNS) begin
					r.fetch_address = {it.roller_word[15:3], 4'd0}
						+ it.roller_word[2:0] + {it.column_number, 3'd0};
				end
			end
			rvfp_pkg::ACT_PIXEL_BYTE: begin
				r.pixel_bits = mode_bits[rvfp_pkg::MODE_INVERT_BIT] ?
					~it.pixel_byte : it.pixel_byte;
			end
			rvfp_pkg::ACT_TICK: begin
				// A count at or past the period fires and starts over.
				tick_count = tick_count + 16'd1;
				if (tick_count >= refresh_period) begin
					r.redraw = 1'b1;
					tick_count = '0;
				end
			end
			default: begin
			end
		endcase
		r.blank = !display_enable || !mode_bits[rvfp_pkg::MODE_ENABLE_BIT];
		return r;
	endfunction

	// Results are checked before the same edge's input is predicted; no result
	// can belong to an item taken at that edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refresh_period = rvfp_pkg::REFRESH_PERIOD_RST;
			display_enable = 1'b1;
			table_base = '0;
			scroll_origin = '0;
			mode_bits = '0;
			tick_count = '0;
			pending_video_results.delete();
			pending <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_video_results.size() == 0) begin
					report_mismatch($sformatf("result transfer with no item waiting: %h", rsp));
				end else begin
					oldest_result = pending_video_results.pop_front();
					if (rsp.fetch_address !== oldest_result.fetch_address) begin
						report_mismatch($sformatf("fetch_address %h, predicted %h",
							rsp.fetch_address, oldest_result.fetch_address));
					end
					if (rsp.pixel_bits !== oldest_result.pixel_bits) begin
						report_mismatch($sformatf("pixel_bits %h, predicted %h",
							rsp.pixel_bits, oldest_result.pixel_bits));
					end
					if (rsp.blank !== oldest_result.blank) begin
						report_mismatch($sformatf("blank %b, predicted %b",
							rsp.blank, oldest_result.blank));
					end
					if (rsp.redraw !== oldest_result.redraw) begin
						report_mismatch($sformatf("redraw %b, predicted %b",
							rsp.redraw, oldest_result.redraw));
					end
				end
			end
			if (req_valid && !req_stall) begin
				pending_video_results.push_back(predict_video_result(req));
			end
			if (cfg_we) begin
				if (cfg_index == rvfp_pkg::CFG_REFRESH_PERIOD) begin
					refresh_period = cfg_data;
				end else begin
					display_enable = cfg_data[0];
				end
			end
			pending <= pending_video_results.size();
		end
	end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

	localparam int COLUMNS = 90;
	localparam int LINES = 256;
	localparam int IDLE_LIMIT = 1000;
	localparam int HOLD_CYCLES = 80;
	localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           req_valid = 1'b0;
	logic           req_stall;
	rvfp_pkg::req_t req = '0;
	logic           rsp_valid;
	logic           rsp_stall = 1'b0;
	rvfp_pkg::rsp_t rsp;
	logic           cfg_we = 1'b0;
	logic           cfg_index = rvfp_pkg::CFG_REFRESH_PERIOD;
	logic [15:0]    cfg_data = '0;

	int fail_count;
	int pending;
	bit no_idle = 1'b0;
	int hold_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	roller_video_fetch_and_pixel_unit #(
		.COLUMNS(COLUMNS),
		.LINES  (LINES)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	rvfp_fetch_checker #(
		.COLUMNS(COLUMNS),
		.LINES  (LINES)
	) u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	// Every field filled with random bits.
	function automatic rvfp_pkg::req_t raw_item();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[$bits(rvfp_pkg::req_t)-1:0];
	endfunction

	// Random item with a mix of actions weighted toward useful ones.
	function automatic rvfp_pkg::req_t random_item();
		rvfp_pkg::req_t it;
		int             pick;
		it = raw_item();
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			it.action = rvfp_pkg::ACT_PORT_WRITE;
			case ($urandom_range(0, 3))
				0: it.port_number = rvfp_pkg::PORT_BASE;
				1: it.port_number = rvfp_pkg::PORT_ORIGIN;
				2: it.port_number = rvfp_pkg::PORT_MODE;
				default: begin
				end
			endcase
		end else if (pick < 35) begin
			it.action = rvfp_pkg::ACT_LINE_REQ;
		end else if (pick < 55) begin
			it.action = rvfp_pkg::ACT_COLUMN_REQ;
			// Most columns past the end are pulled back inside the line.
			if (it.column_number >= COLUMNS && $urandom_range(0, 3) != 0) begin
				it.column_number = it.column_number - 7'd64;
			end
		end else if (pick < 75) begin
			it.action = rvfp_pkg::ACT_PIXEL_BYTE;
		end else if (pick < 95) begin
			it.action = rvfp_pkg::ACT_TICK;
		end else if (it.action <= rvfp_pkg::ACT_TICK) begin
			it.action = ACT_UNUSED_HI;
		end
		return it;
	endfunction

	// Offer one item after a random gap and hold it until the transfer.
	task automatic send_item(input rvfp_pkg::req_t it);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= it;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic send_port(input logic [7:0] port, input logic [7:0] value);
		rvfp_pkg::req_t it;
		it = raw_item();
		it.action = rvfp_pkg::ACT_PORT_WRITE;
		it.port_number = port;
		it.port_value = value;
		send_item(it);
	endtask

	task automatic send_line(input logic [7:0] line);
		rvfp_pkg::req_t it;
		it = raw_item();
		it.action = rvfp_pkg::ACT_LINE_REQ;
		it.line_number = line;
		send_item(it);
	endtask

	task automatic send_column(input logic [15:0] word, input logic [6:0] column);
		rvfp_pkg::req_t it;
		it = raw_item();
		it.action = rvfp_pkg::ACT_COLUMN_REQ;
		it.roller_word = word;
		it.column_number = column;
		send_item(it);
	endtask

	task automatic send_pixel(input logic [7:0] pixels);
		rvfp_pkg::req_t it;
		it = raw_item();
		it.action = rvfp_pkg::ACT_PIXEL_BYTE;
		it.pixel_byte = pixels;
		send_item(it);
	endtask

	task automatic send_ticks(input int count);
		rvfp_pkg::req_t it;
		repeat (count) begin
			it = raw_item();
			it.action = rvfp_pkg::ACT_TICK;
			send_item(it);
		end
	endtask

	// Stop offering and wait until every predicted result has been transferred.
	task automatic wait_for_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_cfg(input logic index, input logic [15:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input logic [15:0] period, input logic enable,
			input bit steady, input int count);
		wait_for_results();
		write_cfg(rvfp_pkg::CFG_REFRESH_PERIOD, period);
		write_cfg(rvfp_pkg::CFG_DISPLAY_ENABLE, {15'd0, enable});
		no_idle = steady;
		repeat (count) send_item(random_item());
	endtask

	// Result side: random stall before each transfer, or one long hold-off on request.
	initial begin : result_sink
		int n;
		forever begin
			if (hold_cycles > 0) begin
				n = hold_cycles;
				hold_cycles = 0;
			end else begin
				n = no_idle ? 0 : $urandom_range(0, 15);
			end
			if (n > 0) begin
				rsp_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	// End the run when no transfer happens on either side for too long.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin : stimulus
		rvfp_pkg::req_t it;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Mode is zero after reset, so pixels come out blank and plain.
		send_pixel(8'h00);
		send_pixel(8'hFF);
		send_port(rvfp_pkg::PORT_MODE, 8'h40);
		send_pixel(8'hA5);
		send_port(rvfp_pkg::PORT_MODE, 8'hC0);
		send_pixel(8'hA5);
		send_pixel(8'h00);

		// Line addresses at the top of memory and with origin wrap.
		send_port(rvfp_pkg::PORT_BASE, 8'hFF);
		send_port(rvfp_pkg::PORT_ORIGIN, 8'hFF);
		send_line(8'h00);
		send_line(8'hFF);
		send_port(rvfp_pkg::PORT_BASE, 8'h00);
		send_port(rvfp_pkg::PORT_ORIGIN, 8'h01);
		send_line(8'hFF);

		// Column addresses, including columns past the end of the line.
		send_column(16'hFFFF, 7'd89);
		send_column(16'h0000, 7'd0);
		send_column(16'h1234, 7'd90);
		send_column(16'hFFFF, 7'd127);

		// Writes to other ports and unused actions leave the mode alone.
		send_port(8'h12, 8'h34);
		send_port(8'h00, 8'h00);
		send_port(8'hFF, 8'hFF);
		it = raw_item();
		it.action = ACT_UNUSED_HI;
		send_item(it);
		send_pixel(8'h5A);

		// Build up the tick count, then lower the period below it.
		send_ticks(20);
		wait_for_results();
		write_cfg(rvfp_pkg::CFG_REFRESH_PERIOD, 16'd18);
		send_ticks(2);

		run_phase(16'd18, 1'b1, 1'b0, 100);
		run_phase(16'hFFFF, 1'b0, 1'b0, 80);
		run_phase(16'd18, 1'b0, 1'b1, 60);

		// Long receiver hold-off while items keep coming back to back.
		wait_for_results();
		hold_cycles = HOLD_CYCLES;
		no_idle = 1'b1;
		repeat (30) send_item(random_item());

		run_phase(16'd30, 1'b1, 1'b0, 100);
		run_phase(16'd75, 1'b1, 1'b0, 100);
		wait_for_results();

		if (fail_count == 0 && pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
